FILE: sv/drm_pkg.sv
// Shared types and constants for the dirty-rectangle merger.
package drm_pkg;

    localparam int unsigned CoordW = 12;
    localparam int unsigned InW    = 16;
    localparam int unsigned AreaW  = 2 * CoordW + 1;
    localparam int unsigned ResultCap = 64;

    typedef logic [CoordW-1:0] coord_t;

    typedef struct packed {
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
    } box_t;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_LIST  = 2'd1,
        OP_FLIP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RAW_FULL = 3'd2,
        ST_NO_BOXES = 3'd3,
        ST_OPT_FULL = 3'd4
    } status_t;

    localparam logic CFG_SCREEN_RIGHT  = 1'b0;
    localparam logic CFG_SCREEN_BOTTOM = 1'b1;

    typedef struct packed {
        op_t                   operation;
        logic signed [InW-1:0] left;
        logic signed [InW-1:0] top;
        logic signed [InW-1:0] right;
        logic signed [InW-1:0] bottom;
    } in_beat_t;

    typedef struct packed {
        coord_t  box_left;
        coord_t  box_top;
        coord_t  box_right;
        coord_t  box_bottom;
        status_t status;
        logic    last;
    } out_beat_t;

    typedef struct packed {
        logic valid;
        box_t bx;
        logic done;
    } probe_t;

    function automatic logic [AreaW-1:0] area(input box_t x);
        logic [CoordW-1:0] w;
        logic [CoordW-1:0] h;
        w = x.r - x.l;
        h = x.b - x.t;
        return AreaW'(w) * AreaW'(h);
    endfunction

endpackage

FILE: sv/drm_if.sv
// Valid/ready channel interface carrying one payload beat.
interface drm_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/drm_cell.sv
// One slot of the optimized list, which tests and absorbs a travelling box.
module drm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            shift_en,
    input  logic            is_tail,
    input  drm_pkg::probe_t probe_in,
    output drm_pkg::probe_t probe_out,
    output drm_pkg::box_t   box,
    output logic            occupied
);
    import drm_pkg::*;

    box_t   box_reg;
    logic   occ_reg;
    probe_t out_reg;
    probe_t probe_next;
    box_t   u;
    logic   take_merge;
    logic   take_append;

    always_comb
    begin
        u.l = (box_reg.l < probe_in.bx.l) ? box_reg.l : probe_in.bx.l;
        u.t = (box_reg.t < probe_in.bx.t) ? box_reg.t : probe_in.bx.t;
        u.r = (box_reg.r > probe_in.bx.r) ? box_reg.r : probe_in.bx.r;
        u.b = (box_reg.b > probe_in.bx.b) ? box_reg.b : probe_in.bx.b;
        take_merge  = probe_in.valid && !probe_in.done && occ_reg &&
                      ((AreaW+1)'(area(u)) <
                       (AreaW+1)'(area(probe_in.bx)) + (AreaW+1)'(area(box_reg)));
        take_append = probe_in.valid && !probe_in.done && !occ_reg && is_tail;
        probe_next      = probe_in;
        probe_next.done = probe_in.done || take_merge || take_append;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            out_reg <= '0;
        end
        else if (clear)
        begin
            occ_reg <= 1'b0;
            out_reg <= '0;
        end
        else if (shift_en)
        begin
            out_reg <= probe_next;
            if (take_append)
                occ_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en && take_merge)
            box_reg <= u;
        else if (shift_en && take_append)
            box_reg <= probe_in.bx;
    end

    assign probe_out = out_reg;
    assign box       = box_reg;
    assign occupied  = occ_reg;
endmodule

FILE: sv/dirty_rectangle_merger.sv
// Dirty-rectangle merger top level: clipping, raw list, cell chain and result sequencer.
// An add beat clips its box, stores it in the raw list and sends it down a chain of
// MERGED_SLOTS cells, one cell a cycle. A list beat emits one result per occupied cell,
// one a cycle while the output is ready. A flip emits the list, then clears the cells
// and replays each raw box through the chain.
module dirty_rectangle_merger #(
    parameter int RAW_SLOTS    = 32,
    parameter int MERGED_SLOTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [11:0] cfg_data,
    drm_if.sink   in_ch,
    drm_if.source out_ch
);
    import drm_pkg::*;

    localparam int RawIdxW = (RAW_SLOTS > 1) ? $clog2(RAW_SLOTS) : 1;
    localparam int RawCntW = $clog2(RAW_SLOTS + 1);
    localparam int MIdxW   = $clog2(MERGED_SLOTS);
    localparam int StepW   = $clog2(MERGED_SLOTS + 2);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_EMIT = 6'b000100,
        S_RAWRD = 6'b001000,
        S_RESP = 6'b010000,
        S_RBWALK = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    coord_t scr_r_reg, scr_b_reg;
    box_t raw_mem [RAW_SLOTS];
    box_t raw_rd_reg;
    logic [RawCntW-1:0] raw_count_reg;
    logic [RawCntW-1:0] rb_idx_reg;
    logic [StepW-1:0] step_reg;
    logic [MIdxW:0] emit_idx_reg;
    logic is_flip_reg;
    status_t resp_status_reg;
    logic out_valid_reg;

    probe_t chain [MERGED_SLOTS+1];
    box_t cell_box [MERGED_SLOTS];
    logic cell_occ [MERGED_SLOTS];
    logic cell_tail [MERGED_SLOTS];
    logic shift_en;
    logic clear_cells;
    probe_t inject;

    logic [MIdxW:0] emit_nxt;
    logic emit_none;
    logic emit_last;
    logic emit_end;

    // Clipping of the incoming box.
    logic signed [InW:0] cl, ct, cr, cb;
    logic empty_clip;
    box_t clip_box;

    always_comb
    begin
        cl = (in_ch.data.left < 0) ? '0 : (InW+1)'(in_ch.data.left);
        ct = (in_ch.data.top < 0) ? '0 : (InW+1)'(in_ch.data.top);
        cr = ((InW+1)'(in_ch.data.right) > $signed({5'd0, scr_r_reg}))
             ? $signed({5'd0, scr_r_reg}) : (InW+1)'(in_ch.data.right);
        cb = ((InW+1)'(in_ch.data.bottom) > $signed({5'd0, scr_b_reg}))
             ? $signed({5'd0, scr_b_reg}) : (InW+1)'(in_ch.data.bottom);
        empty_clip = (cr < cl) || (cb < ct);
        clip_box.l = cl[CoordW-1:0];
        clip_box.t = ct[CoordW-1:0];
        clip_box.r = cr[CoordW-1:0];
        clip_box.b = cb[CoordW-1:0];
    end

    // Occupied cells always form a prefix of the chain.
    always_comb
    begin
        emit_nxt  = emit_idx_reg + 1'b1;
        emit_none = !cell_occ[0];
        emit_last = (int'(emit_nxt) >= ResultCap) || (int'(emit_nxt) >= MERGED_SLOTS) ||
                    !cell_occ[emit_nxt[MIdxW-1:0]];
        emit_end  = emit_none || emit_last;
    end

    genvar g;
    generate
        for (g = 0; g < MERGED_SLOTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign cell_tail[g] = 1'b1;
            end
            else
            begin : g_rest
                assign cell_tail[g] = cell_occ[g-1];
            end
            drm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .clear     (clear_cells),
                .shift_en  (shift_en),
                .is_tail   (cell_tail[g]),
                .probe_in  (chain[g]),
                .probe_out (chain[g+1]),
                .box       (cell_box[g]),
                .occupied  (cell_occ[g])
            );
        end
    endgenerate

    assign chain[0] = inject;
    assign shift_en = (state_reg == S_WALK) || (state_reg == S_RBWALK);

    logic accept_in;
    logic out_fire;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept_in   = in_ch.valid && in_ch.ready;
    assign out_fire    = out_valid_reg && out_ch.ready;

    logic add_ok;
    assign add_ok = accept_in && (in_ch.data.operation == OP_ADD) && !empty_clip &&
                    (raw_count_reg < RawCntW'(RAW_SLOTS));

    always_comb
    begin
        inject = '0;
        clear_cells = 1'b0;
        if (state_reg == S_WALK && step_reg == '0)
        begin
            inject.valid = 1'b1;
            inject.bx    = raw_rd_reg;
        end
        if (state_reg == S_RBWALK && step_reg == '0)
        begin
            inject.valid = 1'b1;
            inject.bx    = raw_rd_reg;
        end
        if (state_reg == S_EMIT && is_flip_reg && out_fire && emit_end)
            clear_cells = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (add_ok)
            raw_mem[raw_count_reg[RawIdxW-1:0]] <= clip_box;
        if (add_ok)
            raw_rd_reg <= clip_box;
        else if (state_reg == S_RAWRD)
            raw_rd_reg <= raw_mem[rb_idx_reg[RawIdxW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_r_reg <= CoordW'(639);
            scr_b_reg <= CoordW'(479);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SCREEN_RIGHT)
                scr_r_reg <= cfg_data;
            else
                scr_b_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept_in)
                begin
                    case (in_ch.data.operation)
                        OP_ADD:   state_next = add_ok ? S_WALK : S_RESP;
                        OP_LIST,
                        OP_FLIP:  state_next = S_EMIT;
                        default:  state_next = S_RESP;
                    endcase
                end
            S_WALK:
                if (step_reg == StepW'(MERGED_SLOTS))
                    state_next = S_RESP;
            S_EMIT:
                if (out_fire && emit_end)
                    state_next = is_flip_reg ? S_RAWRD : S_IDLE;
            S_RAWRD:
                state_next = (rb_idx_reg < raw_count_reg) ? S_RBWALK : S_IDLE;
            S_RBWALK:
                if (step_reg == StepW'(MERGED_SLOTS))
                    state_next = S_RAWRD;
            S_RESP:
                if (out_fire)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            raw_count_reg   <= '0;
            rb_idx_reg      <= '0;
            step_reg        <= '0;
            emit_idx_reg    <= '0;
            is_flip_reg     <= 1'b0;
            resp_status_reg <= ST_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    if (accept_in)
                    begin
                        step_reg     <= '0;
                        emit_idx_reg <= '0;
                        is_flip_reg  <= (in_ch.data.operation == OP_FLIP);
                        case (in_ch.data.operation)
                            OP_ADD:
                                if (empty_clip)
                                    resp_status_reg <= ST_EMPTY;
                                else if (!add_ok)
                                    resp_status_reg <= ST_RAW_FULL;
                                else
                                begin
                                    resp_status_reg <= ST_OK;
                                    raw_count_reg   <= raw_count_reg + 1'b1;
                                end
                            OP_LIST,
                            OP_FLIP:
                                out_valid_reg <= 1'b1;
                            default:
                            begin
                                resp_status_reg <= ST_OK;
                                raw_count_reg   <= '0;
                            end
                        endcase
                        if (!add_ok && in_ch.data.operation == OP_ADD)
                            out_valid_reg <= 1'b1;
                        if (in_ch.data.operation == OP_CLEAR)
                            out_valid_reg <= 1'b1;
                    end
                S_WALK:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == StepW'(MERGED_SLOTS))
                    begin
                        out_valid_reg <= 1'b1;
                        if (!chain[MERGED_SLOTS].done)
                            resp_status_reg <= ST_OPT_FULL;
                    end
                end
                S_EMIT:
                    if (out_fire)
                    begin
                        emit_idx_reg <= emit_nxt;
                        if (emit_end)
                        begin
                            rb_idx_reg    <= '0;
                            out_valid_reg <= 1'b0;
                        end
                    end
                S_RAWRD:
                begin
                    step_reg   <= '0;
                    rb_idx_reg <= rb_idx_reg + 1'b1;
                end
                S_RBWALK:
                    step_reg <= step_reg + 1'b1;
                S_RESP:
                    if (out_fire)
                        out_valid_reg <= 1'b0;
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        out_ch.valid = out_valid_reg;
        out_ch.data  = '0;
        if (state_reg == S_EMIT)
        begin
            if (emit_none)
            begin
                out_ch.data.status = ST_NO_BOXES;
                out_ch.data.last   = 1'b1;
            end
            else
            begin
                out_ch.data.box_left   = cell_box[emit_idx_reg[MIdxW-1:0]].l;
                out_ch.data.box_top    = cell_box[emit_idx_reg[MIdxW-1:0]].t;
                out_ch.data.box_right  = cell_box[emit_idx_reg[MIdxW-1:0]].r;
                out_ch.data.box_bottom = cell_box[emit_idx_reg[MIdxW-1:0]].b;
                out_ch.data.status     = ST_OK;
                out_ch.data.last       = emit_last;
            end
        end
        else
        begin
            out_ch.data.status = resp_status_reg;
            out_ch.data.last   = 1'b1;
        end
    end
endmodule

FILE: tb/sv/dirty_rectangle_merger_test.sv
// Self-checking testbench for the dirty-rectangle merger with a predictor of its box lists.
module dirty_rectangle_merger_test;
    import drm_pkg::*;

    localparam int RawSlots    = 32;
    localparam int MergedSlots = 64;
    localparam int SettleCycles = 2600;
    localparam int CycleLimit  = 1500000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [11:0] cfg_data;

    drm_if #(.payload_t(in_beat_t))  in_ch();
    drm_if #(.payload_t(out_beat_t)) out_ch();

    dirty_rectangle_merger #(.RAW_SLOTS(RawSlots), .MERGED_SLOTS(MergedSlots)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    in_beat_t  pending_items[$];
    out_beat_t expected_boxes[$];

    int   screen_x;
    int   screen_y;
    box_t raw_list[RawSlots];
    int   raw_n;
    box_t opt_list[MergedSlots];
    int   opt_n;

    int   errors;
    int   cycles;
    bit   in_taken;
    int   send_gap;
    int   recv_gap;
    int   hold_left;
    bit   hold_request;
    bit   calm;

    always #5 clk = ~clk;

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic longint box_area(input box_t x);
        return longint'(x.r - x.l) * longint'(x.b - x.t);
    endfunction

    function automatic bit merge_into_opt(input box_t nb);
        box_t e;
        box_t u;
        for (int i = 0; i < opt_n; i++)
        begin
            e = opt_list[i];
            u.l = e.l < nb.l ? e.l : nb.l;
            u.t = e.t < nb.t ? e.t : nb.t;
            u.r = e.r > nb.r ? e.r : nb.r;
            u.b = e.b > nb.b ? e.b : nb.b;
            if (box_area(u) < box_area(nb) + box_area(e))
            begin
                opt_list[i] = u;
                return 1'b1;
            end
        end
        if (opt_n >= MergedSlots)
            return 1'b0;
        opt_list[opt_n] = nb;
        opt_n++;
        return 1'b1;
    endfunction

    function automatic out_beat_t status_beat(input status_t st);
        out_beat_t o;
        o = '0;
        o.status = st;
        o.last = 1'b1;
        return o;
    endfunction

    task automatic expect_opt_list();
        int n;
        out_beat_t o;
        n = opt_n > ResultCap ? ResultCap : opt_n;
        if (n == 0)
            expected_boxes.push_back(status_beat(ST_NO_BOXES));
        for (int i = 0; i < n; i++)
        begin
            o.box_left = opt_list[i].l;
            o.box_top = opt_list[i].t;
            o.box_right = opt_list[i].r;
            o.box_bottom = opt_list[i].b;
            o.status = ST_OK;
            o.last = (i + 1 == n);
            expected_boxes.push_back(o);
        end
    endtask

    task automatic predict_boxes(input in_beat_t it);
        int   l;
        int   t;
        int   r;
        int   b;
        box_t nb;
        case (it.operation)
            OP_ADD:
            begin
                l = it.left;
                t = it.top;
                r = it.right;
                b = it.bottom;
                if (l < 0) l = 0;
                if (t < 0) t = 0;
                if (r > screen_x) r = screen_x;
                if (b > screen_y) b = screen_y;
                if (r < l || b < t)
                    expected_boxes.push_back(status_beat(ST_EMPTY));
                else if (raw_n >= RawSlots)
                    expected_boxes.push_back(status_beat(ST_RAW_FULL));
                else
                begin
                    nb.l = coord_t'(l);
                    nb.t = coord_t'(t);
                    nb.r = coord_t'(r);
                    nb.b = coord_t'(b);
                    raw_list[raw_n] = nb;
                    raw_n++;
                    expected_boxes.push_back(status_beat(merge_into_opt(nb) ? ST_OK
                                                                            : ST_OPT_FULL));
                end
            end
            OP_LIST:
                expect_opt_list();
            OP_FLIP:
            begin
                expect_opt_list();
                opt_n = 0;
                for (int i = 0; i < raw_n; i++)
                    void'(merge_into_opt(raw_list[i]));
            end
            default:
            begin
                raw_n = 0;
                expected_boxes.push_back(status_beat(ST_OK));
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        out_beat_t want;
        out_beat_t got;
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("dirty_rectangle_merger regression: fail");
            $finish;
        end
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                predict_boxes(in_ch.data);
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (expected_boxes.size() == 0)
                    report("result beat with nothing expected");
                else
                begin
                    want = expected_boxes.pop_front();
                    if (got.box_left !== want.box_left)
                        report($sformatf("box_left %0d, wanted %0d", got.box_left,
                                         want.box_left));
                    if (got.box_top !== want.box_top)
                        report($sformatf("box_top %0d, wanted %0d", got.box_top,
                                         want.box_top));
                    if (got.box_right !== want.box_right)
                        report($sformatf("box_right %0d, wanted %0d", got.box_right,
                                         want.box_right));
                    if (got.box_bottom !== want.box_bottom)
                        report($sformatf("box_bottom %0d, wanted %0d", got.box_bottom,
                                         want.box_bottom));
                    if (got.status !== want.status)
                        report($sformatf("status %0d, wanted %0d", got.status, want.status));
                    if (got.last !== want.last)
                        report($sformatf("last %0d, wanted %0d", got.last, want.last));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_ch.data <= pending_items.pop_front();
                in_ch.valid <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 8);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    recv_gap = $urandom_range(1, 8);
            end
        end
    end

    task automatic push_item(input op_t op, input int l, input int t, input int r, input int b);
        in_beat_t it;
        it.operation = op;
        it.left = 16'(l);
        it.top = 16'(t);
        it.right = 16'(r);
        it.bottom = 16'(b);
        pending_items.push_back(it);
    endtask

    function automatic int rand_coord(input int span);
        if ($urandom_range(0, 7) == 0)
            return int'($signed(16'($urandom)));
        return $urandom_range(0, span + 40) - 20;
    endfunction

    task automatic push_random(input int count, input bit points);
        int pick;
        int x;
        int y;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (points)
            begin
                x = $urandom_range(0, screen_x);
                y = $urandom_range(0, screen_y);
                if (pick < 88)
                    push_item(OP_ADD, x, y, x, y);
                else if (pick < 92)
                    push_item(OP_CLEAR, rand_coord(100), 0, 0, 0);
                else if (pick < 96)
                    push_item(OP_LIST, 0, 0, 0, 0);
                else
                    push_item(OP_FLIP, 0, 0, 0, 0);
            end
            else if (pick < 62)
            begin
                x = rand_coord(screen_x);
                y = rand_coord(screen_y);
                push_item(OP_ADD, x, y, x + $urandom_range(0, 200) - 10,
                          y + $urandom_range(0, 200) - 10);
            end
            else if (pick < 66)
                push_item(OP_ADD, rand_coord(screen_x), rand_coord(screen_y),
                          rand_coord(screen_x), rand_coord(screen_y));
            else if (pick < 80)
                push_item(OP_LIST, rand_coord(100), rand_coord(100), 0, 0);
            else if (pick < 92)
                push_item(OP_FLIP, 0, 0, rand_coord(100), rand_coord(100));
            else
                push_item(OP_CLEAR, 0, 0, 0, 0);
        end
    endtask

    task automatic settle();
        while (pending_items.size() > 0 || in_ch.valid || expected_boxes.size() > 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_screen(input int x, input int y);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SCREEN_RIGHT;
        cfg_data <= 12'(x);
        @(negedge clk);
        cfg_index <= CFG_SCREEN_BOTTOM;
        cfg_data <= 12'(y);
        @(negedge clk);
        cfg_we <= 1'b0;
        screen_x = x;
        screen_y = y;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SCREEN_RIGHT;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        screen_x = 639;
        screen_y = 479;
        raw_n = 0;
        opt_n = 0;
        errors = 0;
        cycles = 0;
        in_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;
        hold_request = 1'b0;
        calm = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_item(OP_LIST, 0, 0, 0, 0);
        push_item(OP_FLIP, 0, 0, 0, 0);
        push_item(OP_ADD, -32768, -32768, 32767, 32767);
        push_item(OP_ADD, 10, 10, 20, 20);
        push_item(OP_ADD, 15, 15, 30, 30);
        push_item(OP_ADD, 300, 300, 300, 300);
        push_item(OP_ADD, 50, 10, 40, 20);
        push_item(OP_ADD, 10, 50, 20, 40);
        push_item(OP_ADD, 5000, 5000, 32767, 32767);
        push_item(OP_ADD, 32767, 0, -32768, 0);
        push_item(OP_ADD, 639, 479, 639, 479);
        push_item(OP_LIST, 0, 0, 0, 0);
        push_item(OP_FLIP, 0, 0, 0, 0);
        push_item(OP_LIST, 0, 0, 0, 0);
        push_item(OP_CLEAR, 0, 0, 0, 0);
        push_item(OP_LIST, 0, 0, 0, 0);
        push_item(OP_FLIP, 0, 0, 0, 0);
        push_item(OP_FLIP, 0, 0, 0, 0);
        push_item(OP_ADD, 100, 100, 200, 200);
        push_item(OP_LIST, 0, 0, 0, 0);
        settle();

        write_screen(4095, 4095);
        push_random(10, 1'b0);
        settle();

        write_screen(0, 0);
        push_random(10, 1'b0);
        push_item(OP_ADD, 0, 0, 0, 0);
        push_item(OP_LIST, 0, 0, 0, 0);
        settle();

        write_screen($urandom_range(1, 4095), $urandom_range(1, 4095));
        hold_request = 1'b1;
        push_random(60, 1'b1);
        push_item(OP_LIST, 0, 0, 0, 0);
        settle();

        write_screen(639, 479);
        push_random(5, 1'b0);
        calm = 1'b1;
        push_random(5, 1'b0);
        settle();

        if (errors == 0)
            $display("dirty_rectangle_merger regression: pass");
        else
            $display("dirty_rectangle_merger regression: fail");
        $finish;
    end
endmodule
